// ===== sv/tmps_pkg.sv =====
`default_nettype none

package tmps_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_ROWS_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 16;

   // Fixed field widths of the configuration register and the result.
   localparam int ROW_COUNT_BITS = 7;
   localparam int BEST_SUM_BITS  = 22;

   // One result handed from the update stage to the result queue.
   typedef struct packed {
      logic                            valid;
      logic signed [BEST_SUM_BITS-1:0] sum;
   } tmps_push_type;

endpackage

`default_nettype wire

// ===== sv/tmps_if.sv =====
`default_nettype none

// Request channel: one triangle element per beat.
interface tmps_req_if #(
   parameter int VALUE_BITS = tmps_pkg::VALUE_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// Response channel: one maximum path sum per beat.
interface tmps_rsp_if ();
   logic                                      valid;
   logic                                      ready;
   logic signed [tmps_pkg::BEST_SUM_BITS-1:0] best_sum;

   modport source (output valid, output best_sum, input ready);
   modport sink (input valid, input best_sum, output ready);
endinterface

`default_nettype wire

// ===== sv/tmps_row_store.sv =====
`default_nettype none

// Single-port-write, single-port-read row store with a registered read.
module tmps_row_store #(
   parameter int DEPTH = tmps_pkg::MAX_ROWS_DEFAULT,
   parameter int WIDTH = 23
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/tmps_result_queue.sv =====
`default_nettype none

// Two-entry result queue between the update stage and the response channel.
module tmps_result_queue (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire tmps_pkg::tmps_push_type                   push,
   input  wire logic                                      out_ready,
   output logic                                           out_valid,
   output logic signed [tmps_pkg::BEST_SUM_BITS-1:0]      out_data,
   output logic [1:0]                                     count
);

   logic signed [tmps_pkg::BEST_SUM_BITS-1:0] slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.sum;
      end
   end

endmodule

`default_nettype wire

// ===== sv/triangle_max_path_sum_unit.sv =====
`default_nettype none

// Triangle maximum path sum. Elements arrive one beat per cycle on req_bus in row-major order,
// apex first; csr_wdata sets the row count (0 acts as 1, values above MAX_ROWS act as MAX_ROWS)
// and a write restarts the problem. The unit keeps one row of best partial sums in a memory
// with a registered read, updates each entry as the new element plus its better parent, and
// forwards a result written in the same cycle the next row reads it. It sustains one element
// per cycle; the beat that completes a triangle is held off only while two results, counting
// one still in the update stage, are waiting and none leaves the response queue in that cycle.
// The last element's result passes the update stage and the result queue to reach rsp_bus.
module triangle_max_path_sum_unit #(
   parameter int MAX_ROWS   = tmps_pkg::MAX_ROWS_DEFAULT,
   parameter int VALUE_BITS = tmps_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tmps_req_if.sink                                 req_bus,
   tmps_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [tmps_pkg::ROW_COUNT_BITS-1:0] csr_wdata
);

   localparam int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int NEED_W   = VALUE_BITS + $clog2(MAX_ROWS) + 1;
   localparam int SUM_W    = (NEED_W > tmps_pkg::BEST_SUM_BITS) ? NEED_W
                                                                : tmps_pkg::BEST_SUM_BITS;
   localparam int FLOOR_HI = SUM_W - tmps_pkg::BEST_SUM_BITS + 1;
   localparam logic signed [SUM_W-1:0] SUM_FLOOR =
      {{FLOOR_HI{1'b1}}, {(tmps_pkg::BEST_SUM_BITS-1){1'b0}}};

   // Position counters and row limit.
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] rows_last_ff, rows_last_in;

   // Update stage.
   logic                    s1_valid_ff;
   logic signed [SUM_W-1:0] s1_value_ff;
   logic [IDX_W-1:0]        s1_col_ff;
   logic                    s1_has_left_ff;
   logic                    s1_has_right_ff;
   logic                    s1_bottom_ff;
   logic                    s1_final_ff;

   // Forwarding of a write that lands on the address being read.
   logic                    fwd_valid_ff, fwd_valid_in;
   logic signed [SUM_W-1:0] fwd_data_ff;

   logic signed [SUM_W-1:0] left_hold_ff;
   logic signed [SUM_W-1:0] run_max_ff, run_max_in;
   logic signed [SUM_W-1:0] run_max_new;

   logic                    req_fire;
   logic                    final_in;
   logic                    rsp_fire;
   logic [2:0]              pending;
   logic [SUM_W-1:0]        mem_rdata;
   logic signed [SUM_W-1:0] old_here;
   logic signed [SUM_W-1:0] best_parent;
   logic signed [SUM_W-1:0] fresh;
   logic [1:0]              q_count;
   logic                    q_valid;
   tmps_pkg::tmps_push_type push;

   // Admission: a completing beat needs a free queue slot when it reaches the queue.
   assign final_in = (row_ff == rows_last_ff) && (col_ff == row_ff);
   assign rsp_fire = q_valid && rsp_bus.ready;
   assign pending  = {1'b0, q_count} + {2'b00, s1_valid_ff & s1_final_ff};
   assign req_bus.ready = !final_in || (pending <= (3'd1 + {2'b00, rsp_fire}));
   assign req_fire = req_bus.valid && req_bus.ready;

   // Row limit from the configuration write.
   always_comb begin
      int rc;
      rc = int'(csr_wdata);
      if (rc < 1) begin
         rows_last_in = '0;
      end else if (rc > MAX_ROWS) begin
         rows_last_in = IDX_W'(MAX_ROWS - 1);
      end else begin
         rows_last_in = IDX_W'(rc - 1);
      end
   end

   // Position of the next element.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_we) begin
         row_in = '0;
         col_in = '0;
      end else if (req_fire) begin
         if (col_ff == row_ff) begin
            col_in = '0;
            row_in = (row_ff == rows_last_ff) ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         rows_last_ff <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         run_max_ff   <= SUM_FLOOR;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         if (csr_we) begin
            rows_last_ff <= rows_last_in;
         end
         s1_valid_ff  <= req_fire;
         fwd_valid_ff <= fwd_valid_in;
         run_max_ff   <= run_max_in;
      end
   end

   // Stage payload captured with the beat.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_value_ff     <= SUM_W'(req_bus.value);
         s1_col_ff       <= col_ff;
         s1_has_left_ff  <= (col_ff != '0);
         s1_has_right_ff <= (col_ff != row_ff);
         s1_bottom_ff    <= (row_ff == rows_last_ff);
         s1_final_ff     <= final_in;
         fwd_data_ff     <= fresh;
      end
      if (s1_valid_ff) begin
         left_hold_ff <= old_here;
      end
   end

   assign fwd_valid_in = req_fire && s1_valid_ff && (s1_col_ff == col_ff);

   // Row store of best partial sums.
   tmps_row_store #(
      .DEPTH (MAX_ROWS),
      .WIDTH (SUM_W)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (fresh),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (mem_rdata)
   );

   // Max-add of the element against its one or two parents; the apex has none.
   assign old_here = fwd_valid_ff ? fwd_data_ff : signed'(mem_rdata);

   always_comb begin
      if (s1_has_left_ff && s1_has_right_ff) begin
         best_parent = (left_hold_ff > old_here) ? left_hold_ff : old_here;
      end else if (s1_has_left_ff) begin
         best_parent = left_hold_ff;
      end else if (s1_has_right_ff) begin
         best_parent = old_here;
      end else begin
         best_parent = '0;
      end
      fresh = s1_value_ff + best_parent;
   end

   // Running maximum over the bottom row and the result hand-off.
   always_comb begin
      run_max_new = run_max_ff;
      if (s1_valid_ff && s1_bottom_ff && (!s1_has_left_ff || (fresh > run_max_ff))) begin
         run_max_new = fresh;
      end
      push.valid = s1_valid_ff && s1_final_ff;
      push.sum   = run_max_new[tmps_pkg::BEST_SUM_BITS-1:0];
      if (csr_we || push.valid) begin
         run_max_in = SUM_FLOOR;
      end else begin
         run_max_in = run_max_new;
      end
   end

   tmps_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_bus.ready),
      .out_valid (q_valid),
      .out_data  (rsp_bus.best_sum),
      .count     (q_count)
   );

   assign rsp_bus.valid = q_valid;

endmodule

`default_nettype wire

// ===== sv/tmps_checker.sv =====
`default_nettype none

// Port-level checks on the triangle path sum unit.
module tmps_checker (
   input wire logic                                      clock,
   input wire logic                                      reset,
   input wire logic                                      req_valid,
   input wire logic                                      req_ready,
   input wire logic                                      rsp_valid,
   input wire logic                                      rsp_ready,
   input wire logic signed [tmps_pkg::BEST_SUM_BITS-1:0] rsp_best_sum
);

   // A stalled response beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its sum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_best_sum))
      else $error("response sum changed while stalled");

   // A response only rises after a request beat was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request beat");

endmodule

bind triangle_max_path_sum_unit tmps_checker u_tmps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_best_sum (rsp_bus.best_sum)
);

`default_nettype wire
